FILE: design/ndrm_pkg.sv
// Shared constants and types for the nearest delta-R matcher.
package ndrm_pkg;

  // Field widths
  localparam int ETA_W      = 12;
  localparam int PHI_W      = 10;
  localparam int OUT_IDX_W  = 6;
  localparam int OUT_DIST_W = 24;

  // List size and azimuth circle
  localparam int MAX_RECO  = 64;
  localparam int IDX_W     = $clog2(MAX_RECO);
  localparam int CNT_W     = $clog2(MAX_RECO + 1);
  localparam int PHI_STEPS = 2 ** PHI_W;
  localparam int PHI_HALF  = PHI_STEPS / 2;

  // Distance arithmetic
  localparam int SQ_ETA_W = 2 * ETA_W;
  localparam int SQ_PHI_W = 2 * PHI_W;
  localparam int DIST_W   = SQ_ETA_W + 1;
  localparam logic [OUT_DIST_W-1:0] DIST_SAT = '1;

  // Command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_MATCH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Tag that travels with one list entry through the scan pipeline
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

endpackage

FILE: design/ndrm_store.sv
// Reco object memory: one write port, one read port with registered data.
module ndrm_store (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [ndrm_pkg::IDX_W-1:0]                 waddr,
  input  logic [ndrm_pkg::ETA_W+ndrm_pkg::PHI_W-1:0] wdata,
  input  logic [ndrm_pkg::IDX_W-1:0]                 raddr,
  output logic [ndrm_pkg::ETA_W+ndrm_pkg::PHI_W-1:0] rdata
);

  logic [ndrm_pkg::ETA_W+ndrm_pkg::PHI_W-1:0] mem [ndrm_pkg::MAX_RECO];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry; the read data is registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/ndrm_dist.sv
// Two-stage squared delta-R unit: differences, then squares; the sum is combinational.
module ndrm_dist (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ndrm_pkg::scan_tag_t                   in_tag,
  input  logic signed [ndrm_pkg::ETA_W-1:0]     ref_eta,
  input  logic [ndrm_pkg::PHI_W-1:0]            ref_phi,
  input  logic signed [ndrm_pkg::ETA_W-1:0]     reco_eta,
  input  logic [ndrm_pkg::PHI_W-1:0]            reco_phi,
  output ndrm_pkg::scan_tag_t                   res_tag,
  output logic [ndrm_pkg::DIST_W-1:0]           res_dist,
  output logic                                  busy
);

  logic signed [ndrm_pkg::ETA_W:0]  deta;
  logic [ndrm_pkg::ETA_W-1:0]       ade_c;
  logic [ndrm_pkg::PHI_W:0]         dphi;
  logic [ndrm_pkg::PHI_W-1:0]       adp_raw;
  logic [ndrm_pkg::PHI_W:0]         wrap;
  logic [ndrm_pkg::PHI_W-1:0]       adp_c;

  ndrm_pkg::scan_tag_t              tag1;
  logic [ndrm_pkg::ETA_W-1:0]       ade;
  logic [ndrm_pkg::PHI_W-1:0]       adp;
  ndrm_pkg::scan_tag_t              tag2;
  logic [ndrm_pkg::SQ_ETA_W-1:0]    sq_eta;
  logic [ndrm_pkg::SQ_PHI_W-1:0]    sq_phi;

  // Absolute eta difference and wrapped azimuth difference
  always_comb begin
    deta    = {ref_eta[ndrm_pkg::ETA_W-1], ref_eta} - {reco_eta[ndrm_pkg::ETA_W-1], reco_eta};
    ade_c   = deta[ndrm_pkg::ETA_W] ? ndrm_pkg::ETA_W'(-deta) : deta[ndrm_pkg::ETA_W-1:0];
    dphi    = {1'b0, ref_phi} - {1'b0, reco_phi};
    adp_raw = dphi[ndrm_pkg::PHI_W] ? ndrm_pkg::PHI_W'(-dphi) : dphi[ndrm_pkg::PHI_W-1:0];
    wrap    = (ndrm_pkg::PHI_W+1)'(ndrm_pkg::PHI_STEPS) - {1'b0, adp_raw};
    if ({1'b0, adp_raw} > (ndrm_pkg::PHI_W+1)'(ndrm_pkg::PHI_HALF)) begin
      adp_c = wrap[ndrm_pkg::PHI_W-1:0];
    end else begin
      adp_c = adp_raw;
    end
  end

  // Stage 1: register differences
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
    end else begin
      tag1.valid <= in_tag.valid;
    end
    tag1.idx <= in_tag.idx;
    ade      <= ade_c;
    adp      <= adp_c;
  end

  // Stage 2: register squares
  always_ff @(posedge clk) begin
    if (rst) begin
      tag2.valid <= 1'b0;
    end else begin
      tag2.valid <= tag1.valid;
    end
    tag2.idx <= tag1.idx;
    sq_eta   <= ade * ade;
    sq_phi   <= adp * adp;
  end

  // Sum the squares
  assign res_tag  = tag2;
  assign res_dist = {1'b0, sq_eta} + ndrm_pkg::DIST_W'(sq_phi);
  assign busy     = tag1.valid | tag2.valid;

endmodule

FILE: design/nearest_delta_r_matcher.sv
// Top level of the nearest delta-R matcher: command decode, scan control, result register.
//
// Input channel (in_valid/in_ready) carries one command word: command, obj_eta, obj_phi.
//   Clear empties the list, add appends one object (dropped when 64 are held),
//   match searches the list for the object at least squared delta-R.
//   Command code 3 is taken and ignored.
// Output channel (out_valid/out_ready) carries one result word per match:
//   found, match_index, dist_sq (saturated to 24 bits).
// Clear and add need no scan; the next word can be accepted on the next cycle.
// A match on a list of N >= 1 objects proceeds from acceptance to out_valid
// as follows: the scan reads one entry a cycle from the single read port of the
// object memory, then the read and the two distance stages drain, the scan
// closes and the result register is loaded. A match on an empty list reads no
// entries and closes the scan. No input word is taken during a scan.
// A finished result waits in the output register; while it waits, clear and add
// words and a new match are still taken, and that match holds at its end until
// the receiver has taken the earlier result.
// Reset empties the list and drops any pending result; memory contents are
// left as they are and are only read below the list length.
module nearest_delta_r_matcher (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             command,
  input  logic signed [ndrm_pkg::ETA_W-1:0]      obj_eta,
  input  logic [ndrm_pkg::PHI_W-1:0]             obj_phi,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   found,
  output logic [ndrm_pkg::OUT_IDX_W-1:0]         match_index,
  output logic [ndrm_pkg::OUT_DIST_W-1:0]        dist_sq
);

  ndrm_pkg::state_t                      state;
  ndrm_pkg::state_t                      state_next;
  logic [ndrm_pkg::CNT_W-1:0]            count;
  logic [ndrm_pkg::CNT_W-1:0]            issue_cnt;
  logic signed [ndrm_pkg::ETA_W-1:0]     q_eta;
  logic [ndrm_pkg::PHI_W-1:0]            q_phi;
  logic                                  best_have;
  logic [ndrm_pkg::IDX_W-1:0]            best_idx;
  logic [ndrm_pkg::DIST_W-1:0]           best_d;

  logic                                  accept;
  logic                                  do_add;
  logic                                  do_clear;
  logic                                  do_match;
  logic                                  issuing;
  logic                                  scan_end;
  logic                                  load_out;
  logic                                  out_free;

  ndrm_pkg::scan_tag_t                   rd_tag;
  ndrm_pkg::scan_tag_t                   res_tag;
  logic [ndrm_pkg::DIST_W-1:0]           res_dist;
  logic                                  dist_busy;
  logic [ndrm_pkg::ETA_W+ndrm_pkg::PHI_W-1:0] rdata;

  // Decode accepted command words
  assign accept   = in_valid & in_ready;
  assign do_clear = accept & (command == ndrm_pkg::CMD_CLEAR);
  assign do_add   = accept & (command == ndrm_pkg::CMD_ADD)
                    & (count < ndrm_pkg::CNT_W'(ndrm_pkg::MAX_RECO));
  assign do_match = accept & (command == ndrm_pkg::CMD_MATCH);
  assign out_free = ~out_valid | out_ready;
  assign scan_end = (issue_cnt == count) & ~rd_tag.valid & ~dist_busy;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ndrm_pkg::ST_IDLE: begin
        if (do_match) begin
          state_next = ndrm_pkg::ST_SCAN;
        end
      end
      ndrm_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = ndrm_pkg::ST_DONE;
        end
      end
      ndrm_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = ndrm_pkg::ST_IDLE;
        end
      end
      default: state_next = ndrm_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    issuing  = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ndrm_pkg::ST_IDLE: in_ready = 1'b1;
      ndrm_pkg::ST_SCAN: issuing  = (issue_cnt < count);
      ndrm_pkg::ST_DONE: load_out = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ndrm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Track list length
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_clear) begin
      count <= '0;
    end else if (do_add) begin
      count <= count + 1'b1;
    end
  end

  // Latch the query and advance the read address
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt    <= '0;
      rd_tag.valid <= 1'b0;
    end else begin
      rd_tag.valid <= issuing;
      if (do_match) begin
        issue_cnt <= '0;
      end else if (issuing) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
    end
    rd_tag.idx <= issue_cnt[ndrm_pkg::IDX_W-1:0];
    if (do_match) begin
      q_eta <= obj_eta;
      q_phi <= obj_phi;
    end
  end

  ndrm_store u_store (
    .clk   (clk),
    .we    (do_add),
    .waddr (count[ndrm_pkg::IDX_W-1:0]),
    .wdata ({obj_eta, obj_phi}),
    .raddr (issue_cnt[ndrm_pkg::IDX_W-1:0]),
    .rdata (rdata)
  );

  ndrm_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_tag   (rd_tag),
    .ref_eta  (q_eta),
    .ref_phi  (q_phi),
    .reco_eta (rdata[ndrm_pkg::ETA_W+ndrm_pkg::PHI_W-1:ndrm_pkg::PHI_W]),
    .reco_phi (rdata[ndrm_pkg::PHI_W-1:0]),
    .res_tag  (res_tag),
    .res_dist (res_dist),
    .busy     (dist_busy)
  );

  // Keep the nearest entry; ties keep the lower index
  always_ff @(posedge clk) begin
    if (rst) begin
      best_have <= 1'b0;
    end else if (do_match) begin
      best_have <= 1'b0;
    end else if (res_tag.valid) begin
      best_have <= 1'b1;
    end
    if (do_match) begin
      best_idx <= '0;
      best_d   <= '0;
    end else if (res_tag.valid && (!best_have || res_dist < best_d)) begin
      best_idx <= res_tag.idx;
      best_d   <= res_dist;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      found       <= best_have;
      match_index <= ndrm_pkg::OUT_IDX_W'(best_idx);
      if (best_d[ndrm_pkg::DIST_W-1:ndrm_pkg::OUT_DIST_W] != '0) begin
        dist_sq <= ndrm_pkg::DIST_SAT;
      end else begin
        dist_sq <= best_d[ndrm_pkg::OUT_DIST_W-1:0];
      end
    end
  end

endmodule

FILE: design/ndrm_checker.sv
// Port-level checks for the nearest delta-R matcher, bound to the top level.
module ndrm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [1:0]                          command,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                found,
  input logic [ndrm_pkg::OUT_IDX_W-1:0]      match_index,
  input logic [ndrm_pkg::OUT_DIST_W-1:0]     dist_sq
);

  // A result word holds until the receiver takes it
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found)
      && $stable(match_index) && $stable(dist_sq))
    else $error("result word changed while stalled");

  // An empty-list answer carries zero index and zero distance
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_index == '0 && dist_sq == '0)
    else $error("not-found result with nonzero fields");

  // A match word closes the input until its scan is over
  a_match_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == ndrm_pkg::CMD_MATCH |=> !in_ready)
    else $error("input taken right after a match word");

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind nearest_delta_r_matcher ndrm_checker u_ndrm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .command     (command),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .found       (found),
  .match_index (match_index),
  .dist_sq     (dist_sq)
);

FILE: bench/nearest_delta_r_matcher_tb.sv
// Self-checking testbench for the nearest delta-R matcher: directed and random command words.
module nearest_delta_r_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WORD_TARGET = 690;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int END_SETTLE  = 80;

  typedef struct {
    logic                            hit;
    logic [ndrm_pkg::OUT_IDX_W-1:0]  idx;
    logic [ndrm_pkg::OUT_DIST_W-1:0] d2;
  } match_result_t;

  logic                              clk;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [1:0]                        command = ndrm_pkg::CMD_CLEAR;
  logic signed [ndrm_pkg::ETA_W-1:0] obj_eta = '0;
  logic [ndrm_pkg::PHI_W-1:0]        obj_phi = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              found;
  logic [ndrm_pkg::OUT_IDX_W-1:0]    match_index;
  logic [ndrm_pkg::OUT_DIST_W-1:0]   dist_sq;

  // Shadow copy of the object list and the matches still owed by the block
  logic signed [ndrm_pkg::ETA_W-1:0] reco_eta [ndrm_pkg::MAX_RECO];
  logic [ndrm_pkg::PHI_W-1:0]        reco_phi [ndrm_pkg::MAX_RECO];
  int                                reco_len = 0;
  match_result_t                     pending_matches [$];

  // Objects the tests believe are listed, used to aim probes
  logic signed [ndrm_pkg::ETA_W-1:0] aimed_eta [$];
  logic [ndrm_pkg::PHI_W-1:0]        aimed_phi [$];

  int  errors = 0;
  int  cycles = 0;
  int  words_sent = 0;
  int  results_checked = 0;
  int  results_found = 0;
  int  results_saturated = 0;
  int  adds_dropped = 0;
  int  tx_gap = 0;
  bit  tx_no_idle = 1'b0;
  bit  rx_no_stall = 1'b0;
  int  rx_stall_left = 0;

  nearest_delta_r_matcher u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .obj_eta    (obj_eta),
    .obj_phi    (obj_phi),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .match_index(match_index),
    .dist_sq    (dist_sq)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("nearest_delta_r_matcher regression: fail");
      $finish;
    end
  end

  // Squared delta-R with the azimuth difference taken the short way round
  function automatic longint unsigned delta_r_sq(logic signed [ndrm_pkg::ETA_W-1:0] ea,
                                                 logic [ndrm_pkg::PHI_W-1:0] pa,
                                                 logic signed [ndrm_pkg::ETA_W-1:0] eb,
                                                 logic [ndrm_pkg::PHI_W-1:0] pb);
    longint de;
    longint dp;
    de = longint'(ea) - longint'(eb);
    if (de < 0) de = -de;
    dp = longint'(pa % ndrm_pkg::PHI_STEPS) - longint'(pb % ndrm_pkg::PHI_STEPS);
    if (dp < 0) dp = -dp;
    if (ndrm_pkg::PHI_STEPS - dp < dp) dp = ndrm_pkg::PHI_STEPS - dp;
    return de * de + dp * dp;
  endfunction

  // Apply one accepted word to the shadow list; queue the nearest object for a match
  function automatic void track_word(logic [1:0] c, logic signed [ndrm_pkg::ETA_W-1:0] e,
                                     logic [ndrm_pkg::PHI_W-1:0] p);
    match_result_t    res;
    longint unsigned  d;
    longint unsigned  best;
    case (c)
      ndrm_pkg::CMD_CLEAR: reco_len = 0;
      ndrm_pkg::CMD_ADD: begin
        if (reco_len < ndrm_pkg::MAX_RECO) begin
          reco_eta[reco_len] = e;
          reco_phi[reco_len] = ndrm_pkg::PHI_W'(p % ndrm_pkg::PHI_STEPS);
          reco_len++;
        end else begin
          adds_dropped++;
        end
      end
      ndrm_pkg::CMD_MATCH: begin
        res.hit = 1'b0;
        res.idx = '0;
        res.d2  = '0;
        best    = 0;
        // keep the lower index on equal distance
        for (int i = 0; i < reco_len; i++) begin
          d = delta_r_sq(e, p, reco_eta[i], reco_phi[i]);
          if (!res.hit || d < best) begin
            res.hit = 1'b1;
            res.idx = ndrm_pkg::OUT_IDX_W'(i);
            best    = d;
          end
        end
        if (res.hit) begin
          res.d2 = (best > ndrm_pkg::DIST_SAT) ? ndrm_pkg::DIST_SAT
                                               : ndrm_pkg::OUT_DIST_W'(best);
        end
        pending_matches.insert(pending_matches.size(), res);
      end
      default: ;
    endcase
  endfunction

  // Check each result word against the oldest prediction, then track the input word
  always @(posedge clk) begin
    match_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_matches.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected: found=%0b index=%0d dist_sq=%0d",
                 $time, found, match_index, dist_sq);
      end else begin
        want = pending_matches.pop_front();
        results_checked++;
        if (want.hit) results_found++;
        if (want.d2 == ndrm_pkg::DIST_SAT) results_saturated++;
        if (found !== want.hit) begin
          errors++;
          $display("%0t: found expected %0b, got %0b", $time, want.hit, found);
        end
        if (match_index !== want.idx) begin
          errors++;
          $display("%0t: match_index expected %0d, got %0d", $time, want.idx, match_index);
        end
        if (dist_sq !== want.d2) begin
          errors++;
          $display("%0t: dist_sq expected %0d, got %0d", $time, want.d2, dist_sq);
        end
      end
    end
    if (!rst && in_valid && in_ready) track_word(command, obj_eta, obj_phi);
  end

  // Stall lengths: mostly short, now and then long
  function automatic int pick_gap(bit no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Throttle the result side
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else if (rx_no_stall || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
    end else begin
      rx_stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                   : $urandom_range(15, 60);
      out_ready <= 1'b0;
    end
  end

  function automatic logic signed [ndrm_pkg::ETA_W-1:0] rand_eta();
    return ndrm_pkg::ETA_W'($urandom);
  endfunction

  function automatic logic [ndrm_pkg::PHI_W-1:0] rand_phi();
    return ndrm_pkg::PHI_W'($urandom);
  endfunction

  // Present one word and hold it until taken; valid stays up if the next one follows at once
  task automatic send_word(input logic [1:0] c, input logic signed [ndrm_pkg::ETA_W-1:0] e,
                           input logic [ndrm_pkg::PHI_W-1:0] p);
    if (tx_gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (tx_gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= c;
    obj_eta  <= e;
    obj_phi  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    tx_gap = pick_gap(tx_no_idle);
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
  endtask

  task automatic restart_list();
    send_word(ndrm_pkg::CMD_CLEAR, rand_eta(), rand_phi());
    aimed_eta.delete();
    aimed_phi.delete();
  endtask

  task automatic put_reco(input logic signed [ndrm_pkg::ETA_W-1:0] e,
                          input logic [ndrm_pkg::PHI_W-1:0] p);
    send_word(ndrm_pkg::CMD_ADD, e, p);
    if (aimed_eta.size() < ndrm_pkg::MAX_RECO) begin
      aimed_eta.insert(aimed_eta.size(), e);
      aimed_phi.insert(aimed_phi.size(), p);
    end
  endtask

  // Match close to a listed object; the azimuth offset may cross the wrap point
  task automatic probe_near(input int k);
    logic signed [ndrm_pkg::ETA_W-1:0] e;
    logic [ndrm_pkg::PHI_W-1:0]        p;
    e = ndrm_pkg::ETA_W'(int'(aimed_eta[k]) + $urandom_range(0, 6) - 3);
    p = ndrm_pkg::PHI_W'(aimed_phi[k] + $urandom_range(0, 8) - 4);
    send_word(ndrm_pkg::CMD_MATCH, e, p);
  endtask

  // Field extremes, empty list, ties, azimuth wrap, saturation, unused command
  task automatic test_directed();
    restart_list();
    send_word(ndrm_pkg::CMD_MATCH, 12'sd0, 10'd0);
    put_reco(-12'sd2048, 10'd0);
    put_reco(12'sd2047, 10'd1023);
    put_reco(12'sd0, 10'd512);
    put_reco(12'sd0, 10'd512);
    put_reco(-12'sd1, 10'd1);
    send_word(ndrm_pkg::CMD_MATCH, 12'sd0, 10'd512);
    send_word(ndrm_pkg::CMD_MATCH, 12'sd2047, 10'd0);
    send_word(ndrm_pkg::CMD_MATCH, -12'sd2048, 10'd1023);
    send_word(ndrm_pkg::CMD_MATCH, 12'sd0, 10'd0);
    send_word(CMD_UNUSED, 12'sd2047, 10'd1023);
    send_word(ndrm_pkg::CMD_MATCH, -12'sd1, 10'd1);
    restart_list();
    put_reco(-12'sd2048, 10'd0);
    send_word(ndrm_pkg::CMD_MATCH, 12'sd2047, 10'd512);
    send_word(CMD_UNUSED, -12'sd2048, 10'd0);
    send_word(ndrm_pkg::CMD_MATCH, 12'sd2047, 10'd511);
    restart_list();
    send_word(ndrm_pkg::CMD_MATCH, -12'sd2048, 10'd1023);
  endtask

  // Overfill the list; the surplus objects must never be chosen
  task automatic test_full_list();
    logic signed [ndrm_pkg::ETA_W-1:0] extra_eta;
    logic [ndrm_pkg::PHI_W-1:0]        extra_phi;
    extra_eta = rand_eta();
    extra_phi = rand_phi();
    restart_list();
    repeat (ndrm_pkg::MAX_RECO) put_reco(rand_eta(), rand_phi());
    send_word(ndrm_pkg::CMD_ADD, extra_eta, extra_phi);
    send_word(ndrm_pkg::CMD_ADD, rand_eta(), rand_phi());
    probe_near(ndrm_pkg::MAX_RECO - 1);
    probe_near(0);
    send_word(ndrm_pkg::CMD_MATCH, extra_eta, extra_phi);
    send_word(ndrm_pkg::CMD_MATCH, aimed_eta[ndrm_pkg::MAX_RECO - 1],
              aimed_phi[ndrm_pkg::MAX_RECO - 1]);
    send_word(ndrm_pkg::CMD_MATCH, rand_eta(), rand_phi());
  endtask

  // Random events: clear, fill, probe; some stale lists, some noise words
  task automatic test_random_events();
    int r;
    int n_obj;
    int n_probe;
    int k;
    while (words_sent < WORD_TARGET) begin
      r = $urandom_range(0, 99);
      tx_no_idle  = (r < 15);
      rx_no_stall = (r >= 85);
      if ($urandom_range(0, 9) != 0) restart_list();
      r = $urandom_range(0, 99);
      n_obj = (r < 8) ? $urandom_range(40, 70) : (r < 15) ? 0 : $urandom_range(1, 8);
      repeat (n_obj) begin
        if (aimed_eta.size() > 0 && $urandom_range(0, 9) == 0) begin
          k = $urandom_range(0, aimed_eta.size() - 1);
          put_reco(aimed_eta[k], aimed_phi[k]);
        end else begin
          put_reco(rand_eta(), rand_phi());
        end
      end
      n_probe = $urandom_range(1, 6);
      repeat (n_probe) begin
        r = $urandom_range(0, 99);
        if (r < 55 && aimed_eta.size() > 0) probe_near($urandom_range(0, aimed_eta.size() - 1));
        else if (r < 85) send_word(ndrm_pkg::CMD_MATCH, rand_eta(), rand_phi());
        else send_word(2'($urandom), rand_eta(), rand_phi());
      end
      if ($urandom_range(0, 9) == 0) drain();
    end
    tx_no_idle  = 1'b0;
    rx_no_stall = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    drain();
    test_full_list();
    drain();
    test_random_events();
    drain();
    repeat (END_SETTLE) @(posedge clk);
    $display("Sent %0d command words; checked %0d match results, %0d with a nearest object.",
             words_sent, results_checked, results_found);
    $display("Saturated distances: %0d; adds dropped on a full list: %0d.",
             results_saturated, adds_dropped);
    if (errors == 0) begin
      $display("nearest_delta_r_matcher regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("nearest_delta_r_matcher regression: fail");
    end
    $finish;
  end

endmodule
